FILE: rtl/ordered_array_insert_erase_top_macros.svh
// assertion macros for the ordered array block
`ifndef ORDERED_ARRAY_INSERT_ERASE_TOP_MACROS_SVH
`define ORDERED_ARRAY_INSERT_ERASE_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define OAIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define OAIE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OAIE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define OAIE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

FILE: rtl/oaie_pkg.sv
// shared types and constants of the ordered array block
package oaie_pkg;

    localparam int KIND_W   = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam int IN_KIND_LSB    = 0;
    localparam int IN_POS_LSB     = 3;
    localparam int IN_VALUE_LSB   = 10;
    localparam int IN_TDATA_W     = 48;
    localparam int OUT_RV_LSB     = 0;
    localparam int OUT_COUNT_LSB  = 32;
    localparam int OUT_STATUS_LSB = 39;
    localparam int OUT_TDATA_W    = 48;

    localparam logic [KIND_W-1:0] KIND_APPEND = 3'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POP    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_ERASE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

    // what the decoded item turns into
    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_INS,
        CLS_POP,
        CLS_ERA,
        CLS_RD
    } op_cls_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic ins_rd;
        logic ins_wr;
        logic ins_put;
        logic era_rd;
        logic era_wr;
        logic held_dec;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        op_cls_t cls;
        logic    ins_more;
        logic    era_more;
        logic    out_free;
    } dp_sts_t;

endpackage

FILE: rtl/oaie_datapath.sv
// entry memory, count, shift indexes and result register
module oaie_datapath #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [oaie_pkg::KIND_W-1:0]         in_kind,
    input  logic [oaie_pkg::POS_W-1:0]          in_pos,
    input  logic [oaie_pkg::VALUE_W-1:0]        in_value,
    input  oaie_pkg::ctl_cmd_t                  cmd,
    output oaie_pkg::dp_sts_t                   sts,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic signed [oaie_pkg::VALUE_W-1:0] out_read_value,
    output logic [oaie_pkg::COUNT_W-1:0]        out_count,
    output logic [oaie_pkg::STATUS_W-1:0]       out_status
);
    import oaie_pkg::*;

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CMP_W = (CW > POS_W) ? CW : POS_W;

    logic [DATA_WIDTH-1:0] mem [CAPACITY];
    logic [DATA_WIDTH-1:0] mem_rd_reg;
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_wa;
    logic [AW-1:0]         mem_ra;
    logic [DATA_WIDTH-1:0] mem_wd;

    logic [KIND_W-1:0]     kind_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;
    logic [CW-1:0]         held_reg, held_next;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         tgt_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic                  out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] rv_reg;
    logic [COUNT_W-1:0]    cnt_reg;
    logic [STATUS_W-1:0]   st_reg;

    logic [CW-1:0]         idx_m1;
    logic [CMP_W-1:0]      pos_w, held_w;
    logic                  is_full, is_empty;
    op_cls_t               cls;
    logic [STATUS_W-1:0]   eval_status;
    logic signed [VALUE_W-1:0] rv_next;

    assign idx_m1   = idx_reg - CW'(1);
    assign pos_w    = CMP_W'(pos_reg);
    assign held_w   = CMP_W'(held_reg);
    assign is_full  = (held_reg == CW'(CAPACITY));
    assign is_empty = (held_reg == '0);

    // decode the item against the current count
    always_comb
    begin
        cls         = CLS_NONE;
        eval_status = STATUS_OK;
        case (kind_reg)
            KIND_APPEND:
            begin
                if (is_full)
                    eval_status = STATUS_FULL;
                else
                    cls = CLS_INS;
            end
            KIND_INSERT:
            begin
                if (is_full)
                    eval_status = STATUS_FULL;
                else if (pos_w > held_w)
                    eval_status = STATUS_RANGE;
                else
                    cls = CLS_INS;
            end
            KIND_POP:
            begin
                if (is_empty)
                    eval_status = STATUS_EMPTY;
                else
                    cls = CLS_POP;
            end
            KIND_ERASE:
            begin
                if (pos_w >= held_w)
                    eval_status = STATUS_RANGE;
                else
                    cls = CLS_ERA;
            end
            KIND_READ:
            begin
                if (pos_w >= held_w)
                    eval_status = STATUS_RANGE;
                else
                    cls = CLS_RD;
            end
            default:
            begin
                cls         = CLS_NONE;
                eval_status = STATUS_OK;
            end
        endcase
    end

    assign sts.cls      = cls;
    assign sts.ins_more = (idx_reg > tgt_reg);
    assign sts.era_more = (idx_reg < held_reg);
    assign sts.out_free = !out_valid_reg || out_ready;

    // memory port selection
    always_comb
    begin
        mem_re = 1'b0;
        mem_ra = AW'(pos_reg);
        if (cmd.eval && cls == CLS_RD)
        begin
            mem_re = 1'b1;
            mem_ra = AW'(pos_reg);
        end
        else if (cmd.ins_rd)
        begin
            mem_re = 1'b1;
            mem_ra = idx_m1[AW-1:0];
        end
        else if (cmd.era_rd)
        begin
            mem_re = 1'b1;
            mem_ra = idx_reg[AW-1:0];
        end
    end

    always_comb
    begin
        mem_we = cmd.ins_wr || cmd.ins_put || cmd.era_wr;
        mem_wa = idx_reg[AW-1:0];
        mem_wd = mem_rd_reg;
        if (cmd.ins_put)
            mem_wd = val_reg;
        else if (cmd.era_wr)
            mem_wa = idx_m1[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
            mem_rd_reg <= mem[mem_ra];
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.eval)
            idx_next = (cls == CLS_ERA) ? CW'(pos_reg) + CW'(1) : held_reg;
        else if (cmd.ins_wr)
            idx_next = idx_m1;
        else if (cmd.era_wr)
            idx_next = idx_reg + CW'(1);
    end

    always_comb
    begin
        held_next = held_reg;
        if (cmd.ins_put)
            held_next = held_reg + CW'(1);
        else if (cmd.held_dec)
            held_next = held_reg - CW'(1);
    end

    // read value: sign-extended entry, all ones on a failed read
    always_comb
    begin
        rv_next = '0;
        if (kind_reg == KIND_READ)
        begin
            if (status_reg == STATUS_OK)
                rv_next = VALUE_W'($signed(mem_rd_reg));
            else
                rv_next = '1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.load)
        begin
            kind_reg <= in_kind;
            pos_reg  <= in_pos;
            val_reg  <= DATA_WIDTH'(in_value);
        end
        if (cmd.eval)
        begin
            status_reg <= eval_status;
            tgt_reg    <= (kind_reg == KIND_APPEND) ? held_reg : CW'(pos_reg);
        end
        if (cmd.emit)
        begin
            rv_reg  <= rv_next;
            cnt_reg <= COUNT_W'(held_reg);
            st_reg  <= status_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_read_value = rv_reg;
    assign out_count      = cnt_reg;
    assign out_status     = st_reg;

endmodule

FILE: rtl/oaie_ctrl.sv
// sequencer that steps one item through decode, shifting and result hand-off
module oaie_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  oaie_pkg::dp_sts_t  sts,
    output oaie_pkg::ctl_cmd_t cmd
);
    import oaie_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE     = 7'b0000001,
        ST_EVAL     = 7'b0000010,
        ST_INS_LOOP = 7'b0000100,
        ST_INS_WR   = 7'b0001000,
        ST_ERA_LOOP = 7'b0010000,
        ST_ERA_WR   = 7'b0100000,
        ST_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                cmd.eval = 1'b1;
                unique case (sts.cls)
                    CLS_INS: state_next = ST_INS_LOOP;
                    CLS_ERA: state_next = ST_ERA_LOOP;
                    CLS_POP:
                    begin
                        cmd.held_dec = 1'b1;
                        state_next   = ST_DONE;
                    end
                    default: state_next = ST_DONE;
                endcase
            end
            ST_INS_LOOP:
            begin
                // move entries up from the top, then drop the new word in
                if (sts.ins_more)
                begin
                    cmd.ins_rd = 1'b1;
                    state_next = ST_INS_WR;
                end
                else
                begin
                    cmd.ins_put = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_INS_WR:
            begin
                cmd.ins_wr = 1'b1;
                state_next = ST_INS_LOOP;
            end
            ST_ERA_LOOP:
            begin
                if (sts.era_more)
                begin
                    cmd.era_rd = 1'b1;
                    state_next = ST_ERA_WR;
                end
                else
                begin
                    cmd.held_dec = 1'b1;
                    state_next   = ST_DONE;
                end
            end
            ST_ERA_WR:
            begin
                cmd.era_wr = 1'b1;
                state_next = ST_ERA_LOOP;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

FILE: rtl/ordered_array_insert_erase_top.sv
// top level of the ordered array with insert and erase
//
//  channel  direction  tdata fields (low bit up)                    tuser
//  s_axis   in         kind[2:0] position[9:3] value[41:10]         -
//  m_axis   out        read_value[31:0] count[38:32] status[40:39]  -
//
// one item at a time; insert shifts count - position entries up and erase shifts
// count - position - 1 entries down, with count taken before the item, while append,
// read, pop, unused-kind and failed items shift none; each shifted entry costs a
// read/write pair
// reset clears the count and the control state; the entry memory is not cleared
// a stalled result sits in the output register and the next item is still taken
`include "ordered_array_insert_erase_top_macros.svh"
module ordered_array_insert_erase_top #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // kind, position, value, zero pad
    input  logic [oaie_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // read_value, count, status, zero pad
    output logic [oaie_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);
    import oaie_pkg::*;

    ctl_cmd_t                  cmd;
    dp_sts_t                   sts;
    logic signed [VALUE_W-1:0] read_value;
    logic [COUNT_W-1:0]        count;
    logic [STATUS_W-1:0]       status;

    oaie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    oaie_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_kind        (s_axis_tdata[IN_KIND_LSB +: KIND_W]),
        .in_pos         (s_axis_tdata[IN_POS_LSB +: POS_W]),
        .in_value       (s_axis_tdata[IN_VALUE_LSB +: VALUE_W]),
        .cmd            (cmd),
        .sts            (sts),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .out_read_value (read_value),
        .out_count      (count),
        .out_status     (status)
    );

    always_comb
    begin
        m_axis_tdata                                 = '0;
        m_axis_tdata[OUT_RV_LSB +: VALUE_W]          = read_value;
        m_axis_tdata[OUT_COUNT_LSB +: COUNT_W]       = count;
        m_axis_tdata[OUT_STATUS_LSB +: STATUS_W]     = status;
    end

    `OAIE_ASSERT_NXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while one is in flight")
    `OAIE_ASSERT_IMP(a_emit_free, clk, rst_n, cmd.emit, sts.out_free, "result written over an unconsumed result")
    `OAIE_ASSERT_IMP(a_full_count, clk, rst_n, m_axis_tvalid && status == STATUS_FULL, count == COUNT_W'(CAPACITY), "full status with count below capacity")
    `OAIE_ASSERT_IMP(a_empty_count, clk, rst_n, m_axis_tvalid && status == STATUS_EMPTY, count == '0, "empty status with nonzero count")

endmodule
